@@ hdl/olist_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olist_pkg - shared types and constants of the ordered list engine
// Capacity, widths and the control words that the top level sends to the
// row of list cells.
// ----------------------------------------------------------------------------
package olist_pkg;

	localparam int CAPACITY = 16;
	localparam int DATA_W   = 32;
	// count runs 0 .. CAPACITY inclusive
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	// where a cell sits relative to the current fill level
	typedef struct packed {
		logic occ;      // holds a live entry
		logic at_tail;  // first free slot (slot index == count)
		logic is_last;  // last live entry
	} cell_pos_t;

	// broadcast command, one step
	typedef struct packed {
		logic                     shr;   // shift towards the back, insert at front
		logic                     app;   // write at the tail slot
		logic                     rm;    // close the first matching gap
		logic signed [DATA_W-1:0] value;
	} cell_cmd_t;

endpackage

@@ hdl/olist_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olist_cell - one slot of the list
// Holds one entry, compares it with the command value and passes match and
// back-value information along the row.
// ----------------------------------------------------------------------------
module olist_cell (
	input  logic                               clk,
	input  olist_pkg::cell_pos_t               pos,
	input  olist_pkg::cell_cmd_t               cmd,
	input  logic signed [olist_pkg::DATA_W-1:0] left_data,
	input  logic signed [olist_pkg::DATA_W-1:0] right_data,
	input  logic                               hole_in,
	input  logic signed [olist_pkg::DATA_W-1:0] back_in,
	output logic signed [olist_pkg::DATA_W-1:0] data,
	output logic                               hole_out,
	output logic signed [olist_pkg::DATA_W-1:0] back_out
);
	import olist_pkg::*;

	logic signed [DATA_W-1:0] data_q;
	logic                     match;

	always_comb begin
		match    = pos.occ && (data_q == cmd.value);
		// set from the first matching entry onwards
		hole_out = hole_in | match;
		back_out = pos.is_last ? data_q : back_in;
	end

	// payload only, no reset
	always_ff @(posedge clk) begin
		if (cmd.shr && (pos.occ || pos.at_tail)) begin
			data_q <= left_data;
		end else if (cmd.app && pos.at_tail) begin
			data_q <= cmd.value;
		end else if (cmd.rm && pos.occ && hole_out) begin
			data_q <= right_data;
		end
	end

	assign data = data_q;

endmodule

@@ hdl/ordered_list_engine_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_engine_top - bounded double-ended list of signed 32-bit values
// Command in, one result word out per command, list held in a row of cells.
// ----------------------------------------------------------------------------
// Use:
//   Command channel (cmd_valid / cmd_stall) carries op and value: insert at
//   front, insert at back, remove all equal entries, or search. Each word
//   yields exactly one result word on the response channel (rsp_valid /
//   rsp_stall): found, removed_count, list_size, front_value, back_value,
//   overflow. Front/back read as zero on an empty list; an insert into a full
//   list is dropped and flags overflow.
// Sequence:
//   Accept, execute, report: a command is taken in the idle state, run in
//   the execute state and reported from the report state; the next command
//   is taken only once the report step has loaded the output register. A
//   remove closes one gap per cycle across the whole row and stays in the
//   execute state until no equal entry is left.
// Stall:
//   The result sits in an output register; a stalled receiver holds the
//   report step, and no command word is accepted while it is held.
// Reset:
//   arst_n clears the count, FSM and response valid; cell contents are not
//   reset, slots beyond the count are never read.
// ----------------------------------------------------------------------------
module ordered_list_engine_top (
	input  logic                                clk,
	input  logic                                arst_n,
	// command channel
	input  logic                                cmd_valid,
	output logic                                cmd_stall,
	input  logic [1:0]                          op,
	input  logic signed [olist_pkg::DATA_W-1:0] value,
	// response channel
	output logic                                rsp_valid,
	input  logic                                rsp_stall,
	output logic                                found,
	output logic [olist_pkg::CNT_W-1:0]         removed_count,
	output logic [olist_pkg::CNT_W-1:0]         list_size,
	output logic signed [olist_pkg::DATA_W-1:0] front_value,
	output logic signed [olist_pkg::DATA_W-1:0] back_value,
	output logic                                overflow
);
	import olist_pkg::*;

	typedef enum logic [1:0] {
		OP_FRONT  = 2'd0,
		OP_BACK   = 2'd1,
		OP_REMOVE = 2'd2,
		OP_SEARCH = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_REPORT
	} state_t;

	state_t                   state_q;
	op_t                      op_q;
	logic signed [DATA_W-1:0] value_q;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         removed_q;
	logic                     found_q;
	logic                     ovf_q;

	// response register
	logic                     rsp_valid_q;
	logic                     found_o_q;
	logic [CNT_W-1:0]         removed_o_q;
	logic [CNT_W-1:0]         size_o_q;
	logic signed [DATA_W-1:0] front_o_q;
	logic signed [DATA_W-1:0] back_o_q;
	logic                     ovf_o_q;

	// row of cells
	cell_pos_t                pos      [CAPACITY];
	cell_cmd_t                cmd;
	logic signed [DATA_W-1:0] cell_data[CAPACITY];
	logic                     hole     [CAPACITY+1];
	logic signed [DATA_W-1:0] back_ch  [CAPACITY+1];

	logic cmd_acc;
	logic rsp_free;
	logic full;
	logic any_match;
	logic exec;

	assign cmd_stall = (state_q != S_IDLE);
	assign cmd_acc   = cmd_valid && !cmd_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign exec      = (state_q == S_EXEC);
	assign any_match = hole[CAPACITY];

	always_comb begin
		cmd.shr   = exec && (op_q == OP_FRONT) && !full;
		cmd.app   = exec && (op_q == OP_BACK) && !full;
		cmd.rm    = exec && (op_q == OP_REMOVE) && any_match;
		cmd.value = value_q;
	end

	assign hole[0]           = 1'b0;
	assign back_ch[CAPACITY] = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		always_comb begin
			pos[i].occ     = (CNT_W'(i) < count_q);
			pos[i].at_tail = (CNT_W'(i) == count_q);
			pos[i].is_last = (CNT_W'(i + 1) == count_q);
		end

		olist_cell u_cell (
			.clk        (clk),
			.pos        (pos[i]),
			.cmd        (cmd),
			.left_data  ((i == 0) ? value_q : cell_data[(i == 0) ? 0 : i - 1]),
			.right_data (cell_data[(i == CAPACITY - 1) ? i : i + 1]),
			.hole_in    (hole[i]),
			.back_in    (back_ch[i+1]),
			.data       (cell_data[i]),
			.hole_out   (hole[i+1]),
			.back_out   (back_ch[i])
		);
	end

	// sequencer: state, count and response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_FRONT;
			count_q     <= '0;
			removed_q   <= '0;
			found_q     <= 1'b0;
			ovf_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			// word taken; the report step reloads it in the same cycle
			if (rsp_valid_q && !rsp_stall && (state_q != S_REPORT)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_acc) begin
						op_q      <= op_t'(op);
						removed_q <= '0;
						found_q   <= 1'b0;
						ovf_q     <= 1'b0;
						state_q   <= S_EXEC;
					end
				end
				S_EXEC: begin
					unique case (op_q)
						OP_FRONT, OP_BACK: begin
							if (full) begin
								ovf_q <= 1'b1;
							end else begin
								count_q <= count_q + CNT_W'(1);
							end
							state_q <= S_REPORT;
						end
						OP_REMOVE: begin
							// one gap closed per cycle until none is left
							if (any_match) begin
								count_q   <= count_q - CNT_W'(1);
								removed_q <= removed_q + CNT_W'(1);
							end else begin
								state_q <= S_REPORT;
							end
						end
						OP_SEARCH: begin
							found_q <= any_match;
							state_q <= S_REPORT;
						end
						default: begin
							state_q <= S_REPORT;
						end
					endcase
				end
				S_REPORT: begin
					if (rsp_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// response payload, no reset
	always_ff @(posedge clk) begin
		if ((state_q == S_REPORT) && rsp_free) begin
			found_o_q   <= found_q;
			removed_o_q <= removed_q;
			size_o_q    <= count_q;
			front_o_q   <= (count_q != '0) ? cell_data[0] : '0;
			back_o_q    <= back_ch[0];
			ovf_o_q     <= ovf_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			value_q <= value;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign found         = found_o_q;
	assign removed_count = removed_o_q;
	assign list_size     = size_o_q;
	assign front_value   = front_o_q;
	assign back_value    = back_o_q;
	assign overflow      = ovf_o_q;

endmodule

@@ hdl/olist_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olist_chk - port level checks for the ordered list engine
// Watches the response channel and the consistency of each result word.
// ----------------------------------------------------------------------------
module olist_chk (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                rsp_valid,
	input logic                                rsp_stall,
	input logic                                found,
	input logic [olist_pkg::CNT_W-1:0]         removed_count,
	input logic [olist_pkg::CNT_W-1:0]         list_size,
	input logic signed [olist_pkg::DATA_W-1:0] front_value,
	input logic signed [olist_pkg::DATA_W-1:0] back_value,
	input logic                                overflow
);
	import olist_pkg::*;

	// stalled word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(list_size) &&
		$stable(front_value) && $stable(back_value) && $stable(removed_count))
		else $error("stalled response word changed");

	a_size_cap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> list_size <= CNT_W'(CAPACITY))
		else $error("list size beyond capacity");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (list_size == '0) |-> (front_value == '0) && (back_value == '0))
		else $error("empty list reports non-zero front or back");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && overflow |->
		(list_size == CNT_W'(CAPACITY)) && (removed_count == '0) && !found)
		else $error("overflow flagged on a list that is not full");

	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (list_size == CNT_W'(1)) |-> front_value == back_value)
		else $error("single entry list has differing front and back");

endmodule

bind ordered_list_engine_top olist_chk u_olist_chk (.*);

@@ sim/tb_ordered_list_engine_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_list_engine_top - self-checking bench for the ordered list engine
// Feeds command words (front/back insert, remove-all-equal, search) through
// the valid/stall channel. A queue-based copy of the list predicts every
// result word, and a monitor compares the words field by field, in order.
// Random idling sits on both sides. One long receiver hold-off fills the
// block, and the sender pauses for an empty pipe before some sequences.
// ----------------------------------------------------------------------------
module tb_ordered_list_engine_top;
	import olist_pkg::*;

	localparam int CLK_HALF   = 4;
	localparam int LIMIT      = 200000;  // cycles
	localparam int N_RANDOM   = 900;
	localparam int TAIL       = 40;      // cycles waited after the last expected result
	localparam int HOLD_LEN   = 150;     // long receiver hold-off
	localparam int HOLD_AT    = 250;     // results seen before the hold-off starts
	localparam int QUIET_LO   = 400;     // no idling on either side in this window
	localparam int QUIET_HI   = 560;
	localparam int IDLE_PCT   = 15;

	typedef enum logic [1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_BACK  = 2'd1,
		OP_REMOVE     = 2'd2,
		OP_SEARCH     = 2'd3
	} list_op_t;

	// one command word waiting to go out
	typedef struct {
		list_op_t                 op;
		logic signed [DATA_W-1:0] value;
		bit                       wait_idle;  // hold back until all results are in
	} cmd_word_t;

	typedef struct packed {
		logic                     found;
		logic [CNT_W-1:0]         removed;
		logic [CNT_W-1:0]         size;
		logic signed [DATA_W-1:0] front;
		logic signed [DATA_W-1:0] back;
		logic                     ovf;
	} list_rsp_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cmd_valid = 1'b0;
	logic                     cmd_stall;
	logic [1:0]               op = 2'd0;
	logic signed [DATA_W-1:0] value = '0;
	logic                     rsp_valid;
	logic                     rsp_stall = 1'b0;
	logic                     found;
	logic [CNT_W-1:0]         removed_count;
	logic [CNT_W-1:0]         list_size;
	logic signed [DATA_W-1:0] front_value;
	logic signed [DATA_W-1:0] back_value;
	logic                     overflow;

	cmd_word_t                cmd_pending[$];
	list_rsp_t                rsp_due[$];     // predicted words, oldest first
	logic signed [DATA_W-1:0] held[$];        // predicted list, front at index 0

	int n_planned = 0;
	int n_acc = 0;
	int n_rsp = 0;
	int fails = 0;
	int cycles = 0;
	int n_ovf = 0;
	int n_full = 0;
	int max_removed = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	ordered_list_engine_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd_stall     (cmd_stall),
		.op            (op),
		.value         (value),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.found         (found),
		.removed_count (removed_count),
		.list_size     (list_size),
		.front_value   (front_value),
		.back_value    (back_value),
		.overflow      (overflow)
	);

	initial begin
		forever #(CLK_HALF) clk = ~clk;
	end

	// ------------------------------------------------------------------
	// List predictor: apply one command to the held copy, give the word
	// ------------------------------------------------------------------
	function automatic list_rsp_t list_apply(input list_op_t o,
	                                         input logic signed [DATA_W-1:0] v);
		list_rsp_t                r;
		logic signed [DATA_W-1:0] kept[$];
		r = '0;
		case (o)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				// full list: word dropped, list untouched
				if (held.size() >= CAPACITY)
					r.ovf = 1'b1;
				else if (o == OP_PUSH_FRONT)
					held.push_front(v);
				else
					held.push_back(v);
			end
			OP_REMOVE: begin
				// every equal entry goes, order of the rest is kept
				foreach (held[i])
					if (held[i] != v)
						kept.push_back(held[i]);
				r.removed = CNT_W'(held.size() - kept.size());
				held = kept;
			end
			OP_SEARCH: begin
				foreach (held[i])
					if (held[i] == v)
						r.found = 1'b1;
			end
		endcase
		r.size = CNT_W'(held.size());
		// empty list reads front/back as zero
		if (held.size() != 0) begin
			r.front = held[0];
			r.back  = held[held.size() - 1];
		end
		return r;
	endfunction

	// small pool so that searches and removes hit; holds the extremes too
	function automatic logic signed [DATA_W-1:0] pool_value(input int idx);
		case (idx)
			0:       return 32'sh7FFF_FFFF;
			1:       return 32'sh8000_0000;
			2:       return 32'sh0000_0000;
			3:       return -32'sd1;
			4:       return 32'sd7;
			5:       return 32'sd1;
			6:       return 32'sh5A5A_5A5A;
			default: return -32'sd100;
		endcase
	endfunction

	function automatic logic signed [DATA_W-1:0] pool_pick();
		return pool_value($urandom_range(7));
	endfunction

	function automatic list_op_t pick_op();
		int r;
		r = $urandom_range(99);
		if (r < 25)
			return OP_PUSH_FRONT;
		else if (r < 50)
			return OP_PUSH_BACK;
		else if (r < 70)
			return OP_REMOVE;
		else
			return OP_SEARCH;
	endfunction

	function automatic list_op_t pick_side();
		return ($urandom_range(1) != 0) ? OP_PUSH_FRONT : OP_PUSH_BACK;
	endfunction

	task automatic queue_word(input list_op_t o, input logic signed [DATA_W-1:0] v,
	                          input bit wait_idle = 1'b0);
		cmd_word_t w;
		w.op        = o;
		w.value     = v;
		w.wait_idle = wait_idle;
		cmd_pending.push_back(w);
	endtask

	// ------------------------------------------------------------------
	// Directed opening: empty list, extremes, duplicates, full list
	// ------------------------------------------------------------------
	task automatic plan_directed();
		queue_word(OP_SEARCH, pool_value(4));        // search on empty list
		queue_word(OP_REMOVE, pool_value(4));        // remove on empty list
		queue_word(OP_PUSH_FRONT, pool_value(0));    // most positive
		queue_word(OP_PUSH_BACK, pool_value(1));     // most negative
		queue_word(OP_PUSH_FRONT, pool_value(2));
		queue_word(OP_PUSH_BACK, pool_value(3));
		queue_word(OP_PUSH_FRONT, pool_value(4));    // duplicates at both ends
		queue_word(OP_PUSH_BACK, pool_value(4));
		queue_word(OP_SEARCH, pool_value(4));        // hit
		queue_word(OP_SEARCH, pool_value(5));        // miss
		queue_word(OP_REMOVE, pool_value(4));        // both copies go
		queue_word(OP_REMOVE, pool_value(5));        // absent value
		queue_word(OP_SEARCH, pool_value(1));
		// fill to capacity from both ends
		for (int i = 0; i < CAPACITY - 4; i++)
			queue_word((i % 2 == 0) ? OP_PUSH_BACK : OP_PUSH_FRONT,
			           (i % 3 == 0) ? pool_value(7) : pool_value(5));
		queue_word(OP_PUSH_FRONT, pool_value(2));    // full: dropped
		queue_word(OP_PUSH_BACK, pool_value(2));     // full: dropped
		queue_word(OP_REMOVE, pool_value(5));
	endtask

	// ------------------------------------------------------------------
	// Random part, built from short sequences so that the list moves
	// between empty and full. Values outside the pool only live within
	// one sequence, so removing the pool empties the list.
	// ------------------------------------------------------------------
	task automatic plan_random(input int target);
		int                       n;
		int                       kind;
		int                       len;
		logic signed [DATA_W-1:0] v;
		logic signed [DATA_W-1:0] wide[$];
		n = 0;
		while (n < target) begin
			kind = $urandom_range(99);
			if (kind < 40) begin
				// free mix over the pool
				len = $urandom_range(30, 5);
				repeat (len)
					queue_word(pick_op(), pool_pick());
				n += len;
			end else if (kind < 60) begin
				// fill run, often into overflow, then a few probes
				len = $urandom_range(22, 8);
				repeat (len)
					queue_word(pick_side(), pool_pick());
				repeat (3)
					queue_word(OP_SEARCH, pool_pick());
				n += len + 3;
			end else if (kind < 75) begin
				// drain run
				len = $urandom_range(10, 3);
				repeat (len)
					queue_word(($urandom_range(3) == 0) ? OP_SEARCH : OP_REMOVE,
					           pool_pick());
				n += len;
			end else if (kind < 90) begin
				// full-width values: insert, probe, remove again
				wide = {};
				len  = $urandom_range(6, 1);
				repeat (len) begin
					v = $urandom;
					wide.push_back(v);
					queue_word(pick_side(), v);
				end
				foreach (wide[i]) begin
					queue_word(OP_SEARCH, wide[i]);
					queue_word(OP_SEARCH, $urandom);
				end
				foreach (wide[i])
					queue_word(OP_REMOVE, wide[i]);
				n += 4 * len;
			end else begin
				// clear, fill with one value, remove the lot; starts on an empty pipe
				for (int i = 0; i < 8; i++)
					queue_word(OP_REMOVE, pool_value(i), i == 0);
				v = pool_pick();
				repeat (CAPACITY + 1)
					queue_word(pick_side(), v);
				queue_word(OP_SEARCH, v);
				queue_word(OP_REMOVE, v);
				queue_word(OP_SEARCH, v);
				n += 8 + CAPACITY + 4;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Driver: offers the pending words, predicts on each acceptance
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		int        acc_now;
		bit        quiet;
		cmd_word_t w;
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			op        <= OP_SEARCH;
			value     <= '0;
			n_acc     <= 0;
		end else begin
			acc_now = n_acc;
			if (cmd_valid && !cmd_stall) begin
				rsp_due.push_back(list_apply(list_op_t'(op), value));
				acc_now++;
				n_acc <= acc_now;
			end
			// payload only moves when the slot is free
			if (!cmd_valid || !cmd_stall) begin
				quiet = (acc_now >= QUIET_LO) && (acc_now < QUIET_HI);
				if (cmd_pending.size() != 0
				    && !(cmd_pending[0].wait_idle && acc_now != n_rsp)
				    && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
					w = cmd_pending.pop_front();
					cmd_valid <= 1'b1;
					op        <= w.op;
					value     <= w.value;
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver stall: random idling, one long hold-off, a quiet window
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= (hold_left > 1);
		end else if (!hold_done && n_rsp >= HOLD_AT) begin
			// sender keeps going, so the block backs up and stalls its input
			hold_left <= HOLD_LEN;
			hold_done <= 1'b1;
			rsp_stall <= 1'b1;
		end else if (n_rsp >= QUIET_LO && n_rsp < QUIET_HI) begin
			rsp_stall <= 1'b0;
		end else begin
			rsp_stall <= ($urandom_range(99) < IDLE_PCT);
		end
	end

	function automatic void check_field(input string name, input logic [DATA_W-1:0] exp_v,
	                                    input logic [DATA_W-1:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected 0x%08h, actual 0x%08h", name, exp_v, act_v);
			fails++;
		end
	endfunction

	// ------------------------------------------------------------------
	// Monitor: every accepted result word against the oldest prediction
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		list_rsp_t exp_w;
		if (!arst_n) begin
			n_rsp <= 0;
		end else if (rsp_valid && !rsp_stall) begin
			n_rsp <= n_rsp + 1;
			if (rsp_due.size() == 0) begin
				$error("result word with nothing outstanding");
				fails++;
			end else begin
				exp_w = rsp_due.pop_front();
				check_field("found", exp_w.found, found);
				check_field("removed_count", exp_w.removed, removed_count);
				check_field("list_size", exp_w.size, list_size);
				check_field("front_value", exp_w.front, front_value);
				check_field("back_value", exp_w.back, back_value);
				check_field("overflow", exp_w.ovf, overflow);
				if (exp_w.ovf)
					n_ovf++;
				if (exp_w.size == CAPACITY)
					n_full++;
				if (exp_w.removed > max_removed)
					max_removed = exp_w.removed;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("[ordered_list_engine_top] ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		int n_dir;
		plan_directed();
		n_dir = cmd_pending.size();
		plan_random(N_RANDOM);
		// random part starts on an empty pipe
		cmd_pending[n_dir].wait_idle = 1'b1;
		n_planned = cmd_pending.size();

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// one result word per command
		while (n_rsp < n_planned)
			@(posedge clk);
		repeat (TAIL) @(posedge clk);

		if (rsp_due.size() != 0) begin
			$error("%0d predicted words never arrived", rsp_due.size());
			fails++;
		end

		$display("%0d commands, %0d results; full list seen %0d times, %0d dropped inserts",
		         n_planned, n_rsp, n_full, n_ovf);
		$display("largest single removal %0d entries, %0d mismatches", max_removed, fails);
		if (fails == 0)
			$display("[ordered_list_engine_top] OK");
		else
			$display("[ordered_list_engine_top] ERROR");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/olist_pkg.sv
hdl/olist_cell.sv
hdl/ordered_list_engine_top.sv
hdl/olist_chk.sv
sim/tb_ordered_list_engine_top.sv
